/* design/instruction_word_decoder_macros.svh */
// Assertion helpers for the instruction word decoder.
`ifndef INSTRUCTION_WORD_DECODER_MACROS_SVH
`define INSTRUCTION_WORD_DECODER_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define IWD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define IWD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/iwd_pkg.sv */
package iwd_pkg;

    localparam int unsigned InstrWidth = 32;
    localparam int unsigned OutWidth   = 96;

    // operation classes
    localparam logic [4:0] OP_MUL   = 5'd0;
    localparam logic [4:0] OP_MLA   = 5'd1;
    localparam logic [4:0] OP_UMULL = 5'd2;
    localparam logic [4:0] OP_SWP   = 5'd6;
    localparam logic [4:0] OP_LDRH  = 5'd7;
    localparam logic [4:0] OP_STRH  = 5'd8;
    localparam logic [4:0] OP_LDRSB = 5'd9;
    localparam logic [4:0] OP_LDRSH = 5'd10;
    localparam logic [4:0] OP_MRS   = 5'd11;
    localparam logic [4:0] OP_MSR   = 5'd12;
    localparam logic [4:0] OP_BX    = 5'd13;
    localparam logic [4:0] OP_LDM   = 5'd14;
    localparam logic [4:0] OP_STM   = 5'd15;
    localparam logic [4:0] OP_LDR   = 5'd16;
    localparam logic [4:0] OP_STR   = 5'd17;
    localparam logic [4:0] OP_B     = 5'd18;
    localparam logic [4:0] OP_ALU   = 5'd19;
    localparam logic [4:0] OP_UNDEC = 5'd20;

    // flag bit positions
    localparam logic [2:0] FLAG_S  = 3'd0;
    localparam logic [2:0] FLAG_L  = 3'd1;
    localparam logic [2:0] FLAG_U  = 3'd2;
    localparam logic [2:0] FLAG_P  = 3'd3;
    localparam logic [2:0] FLAG_W  = 3'd4;
    localparam logic [2:0] FLAG_I  = 3'd5;
    localparam logic [2:0] FLAG_B  = 3'd6;
    localparam logic [2:0] FLAG_SR = 3'd7;

    // encoding group masks and patterns, in priority order but for RSVD_PAT, tested after DPRS_PAT
    localparam logic [31:0] MUL_MASK    = 32'h0FC0_00F0;
    localparam logic [31:0] MUL_PAT     = 32'h0000_0090;
    localparam logic [31:0] MULL_MASK   = 32'h0F80_00F0;
    localparam logic [31:0] MULL_PAT    = 32'h0080_0090;
    localparam logic [31:0] SWP_MASK    = 32'h0FB0_0FF0;
    localparam logic [31:0] SWP_PAT     = 32'h0100_0090;
    localparam logic [31:0] HW_MASK     = 32'h0E00_00F0;
    localparam logic [31:0] HW_PAT      = 32'h0000_00B0;
    localparam logic [31:0] SGN_MASK    = 32'h0E10_00D0;
    localparam logic [31:0] SGN_PAT     = 32'h0010_00D0;
    localparam logic [31:0] PSR_MASK    = 32'h0FB0_00F0;
    localparam logic [31:0] MRS_PAT     = 32'h0100_0000;
    localparam logic [31:0] MSR_PAT     = 32'h0120_0000;
    localparam logic [31:0] IMM_MASK    = 32'h0FB0_0000;
    localparam logic [31:0] MSRI_PAT    = 32'h0320_0000;
    localparam logic [31:0] RSVD_PAT    = 32'h0300_0000;
    localparam logic [31:0] BX_MASK     = 32'h0FFF_FFF0;
    localparam logic [31:0] BX_PAT      = 32'h012F_FF10;
    localparam logic [31:0] GRP_MASK    = 32'h0E00_0000;
    localparam logic [31:0] BLK_PAT     = 32'h0800_0000;
    localparam logic [31:0] SDT_PAT     = 32'h0400_0000;
    localparam logic [31:0] SDTR_MASK   = 32'h0E00_0010;
    localparam logic [31:0] SDTR_PAT    = 32'h0600_0000;
    localparam logic [31:0] BR_PAT      = 32'h0A00_0000;
    localparam logic [31:0] DPIS_MASK   = 32'h0E00_0010;
    localparam logic [31:0] DPIS_PAT    = 32'h0000_0000;
    localparam logic [31:0] DPRS_MASK   = 32'h0E00_0090;
    localparam logic [31:0] DPRS_PAT    = 32'h0000_0010;
    localparam logic [31:0] DPI_PAT     = 32'h0200_0000;

    typedef struct packed {
        logic [15:0] register_list;
        logic [4:0]  shift_count;
        logic [1:0]  shift_kind;
        logic [31:0] imm_value;
        logic [7:0]  flag_bits;
        logic [3:0]  second_reg;
        logic [3:0]  shift_reg;
        logic [3:0]  base_reg;
        logic [3:0]  dest_reg;
        logic [3:0]  alu_op;
        logic [3:0]  cond_code;
        logic [4:0]  op_class;
    } iwd_result_t;

    function automatic logic [31:0] iwd_rot_imm(input logic [31:0] w);
        logic [63:0] dbl;
        logic [5:0]  amt;
        dbl = {2{24'd0, w[7:0]}};
        amt = {1'b0, w[11:8], 1'b0};
        dbl = dbl >> amt;
        return dbl[31:0];
    endfunction

    function automatic iwd_result_t iwd_decode(input logic [31:0] w);
        iwd_result_t r;
        r = '0;
        r.op_class  = OP_UNDEC;
        r.cond_code = w[31:28];
        if ((w & MUL_MASK) == MUL_PAT) begin
            r.op_class = w[21] ? OP_MLA : OP_MUL;
            r.flag_bits[FLAG_S] = w[20];
            r.dest_reg   = w[19:16];
            r.base_reg   = w[15:12];
            r.shift_reg  = w[11:8];
            r.second_reg = w[3:0];
        end else if ((w & MULL_MASK) == MULL_PAT) begin
            r.op_class = OP_UMULL + {3'd0, w[22:21]};
            r.flag_bits[FLAG_S] = w[20];
            r.dest_reg   = w[19:16];
            r.base_reg   = w[15:12];
            r.shift_reg  = w[11:8];
            r.second_reg = w[3:0];
        end else if ((w & SWP_MASK) == SWP_PAT) begin
            // swap with the PC as source stays undecoded
            if (w[3:0] != 4'hF) begin
                r.op_class = OP_SWP;
                r.flag_bits[FLAG_B] = w[22];
                r.base_reg   = w[19:16];
                r.dest_reg   = w[15:12];
                r.second_reg = w[3:0];
            end
        end else if ((w & HW_MASK) == HW_PAT || (w & SGN_MASK) == SGN_PAT) begin
            if ((w & HW_MASK) == HW_PAT)
                r.op_class = w[20] ? OP_LDRH : OP_STRH;
            else
                r.op_class = w[5] ? OP_LDRSH : OP_LDRSB;
            r.flag_bits[FLAG_L] = w[20];
            r.flag_bits[FLAG_U] = w[23];
            r.flag_bits[FLAG_P] = w[24];
            r.flag_bits[FLAG_W] = w[21];
            r.flag_bits[FLAG_I] = w[22];
            r.base_reg   = w[19:16];
            r.dest_reg   = w[15:12];
            r.second_reg = w[3:0];
            r.imm_value  = {24'd0, w[11:8], w[3:0]};
        end else if ((w & PSR_MASK) == MRS_PAT) begin
            r.op_class = OP_MRS;
            r.flag_bits[FLAG_P] = w[22];
            r.dest_reg = w[15:12];
        end else if ((w & PSR_MASK) == MSR_PAT) begin
            r.op_class = OP_MSR;
            r.flag_bits[FLAG_P] = w[22];
            r.second_reg = w[3:0];
        end else if ((w & IMM_MASK) == MSRI_PAT) begin
            r.op_class = OP_MSR;
            r.flag_bits[FLAG_I] = 1'b1;
            r.flag_bits[FLAG_P] = w[22];
            r.imm_value = iwd_rot_imm(w);
        end else if ((w & BX_MASK) == BX_PAT) begin
            r.op_class = OP_BX;
            r.base_reg = w[3:0];
        end else if ((w & GRP_MASK) == BLK_PAT) begin
            r.op_class = w[20] ? OP_LDM : OP_STM;
            r.flag_bits[FLAG_L] = w[20];
            r.flag_bits[FLAG_U] = w[23];
            r.flag_bits[FLAG_P] = w[24];
            r.flag_bits[FLAG_W] = w[21];
            r.flag_bits[FLAG_S] = w[22];
            r.base_reg      = w[19:16];
            r.register_list = w[15:0];
        end else if ((w & GRP_MASK) == SDT_PAT || (w & SDTR_MASK) == SDTR_PAT) begin
            r.op_class = w[20] ? OP_LDR : OP_STR;
            r.flag_bits[FLAG_L] = w[20];
            r.flag_bits[FLAG_U] = w[23];
            r.flag_bits[FLAG_P] = w[24];
            r.flag_bits[FLAG_W] = w[21];
            r.flag_bits[FLAG_B] = w[22];
            r.base_reg = w[19:16];
            r.dest_reg = w[15:12];
            if (w[25]) begin
                r.flag_bits[FLAG_I] = 1'b1;
                r.second_reg  = w[3:0];
                r.shift_kind  = w[6:5];
                r.shift_count = w[11:7];
            end else begin
                r.imm_value = {20'd0, w[11:0]};
            end
        end else if ((w & GRP_MASK) == BR_PAT) begin
            r.op_class = OP_B;
            r.flag_bits[FLAG_L] = w[24];
            r.imm_value = {{6{w[23]}}, w[23:0], 2'b00};
        end else if ((w & DPIS_MASK) == DPIS_PAT || (w & DPRS_MASK) == DPRS_PAT) begin
            r.op_class = OP_ALU;
            r.alu_op   = w[24:21];
            r.flag_bits[FLAG_S] = w[20];
            r.dest_reg   = w[15:12];
            r.base_reg   = w[19:16];
            r.second_reg = w[3:0];
            r.shift_kind = w[6:5];
            r.imm_value  = {20'd0, w[11:0]};
            if (w[4]) begin
                r.flag_bits[FLAG_SR] = 1'b1;
                r.shift_reg = w[11:8];
            end else begin
                r.shift_count = w[11:7];
            end
        end else if ((w & IMM_MASK) == RSVD_PAT) begin
            r.op_class = OP_UNDEC;
        end else if ((w & GRP_MASK) == DPI_PAT) begin
            r.op_class = OP_ALU;
            r.alu_op   = w[24:21];
            r.flag_bits[FLAG_I] = 1'b1;
            r.flag_bits[FLAG_S] = w[20];
            r.dest_reg  = w[15:12];
            r.base_reg  = w[19:16];
            r.imm_value = iwd_rot_imm(w);
        end
        return r;
    endfunction

endpackage

/* design/instruction_word_decoder.sv */
// Channel   Dir  Ports                    Payload
// s_        in   s_tvalid/tready/tdata    instruction_word [31:0]
// m_        out  m_tvalid/tready/tdata    decoded fields, 92 bits in a 96-bit word
//
// One word per cycle sustained while m_tready stays high; a word transferred in is held in
// the input register, then in the result register, from which it transfers out.
// Stage 1 registers the word, the decode logic sits between it and the result register.
// aresetn (synchronous, active low) clears both valid flags; payload is not reset.
// A stall on m_tready backs up through both stages; each stage refills as soon as
// the one after it moves.
`include "instruction_word_decoder_macros.svh"

module instruction_word_decoder (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [31:0] instruction_word
    input  logic [iwd_pkg::InstrWidth-1:0]    s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [4:0] op_class, [8:5] cond_code, [12:9] alu_op, [16:13] dest_reg,
    // [20:17] base_reg, [24:21] shift_reg, [28:25] second_reg, [36:29] flag_bits,
    // [68:37] imm_value, [70:69] shift_kind, [75:71] shift_count,
    // [91:76] register_list, [95:92] zero
    output logic [iwd_pkg::OutWidth-1:0]      m_tdata
);
    import iwd_pkg::*;

    logic        in_valid_reg;
    logic [31:0] in_word_reg;
    logic        out_valid_reg;
    iwd_result_t out_data_reg;
    iwd_result_t dec_next;
    logic        out_ready;
    logic        in_take;
    logic        out_move;
    logic        out_undec;
    logic        undec_clean;
    logic        out_branch;
    logic        branch_aligned;

    assign out_ready = !out_valid_reg || m_tready;
    assign s_tready  = !in_valid_reg || out_ready;
    assign in_take   = s_tvalid && s_tready;

    always_comb begin
        dec_next = iwd_decode(in_word_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_word_reg <= s_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_ready) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready && in_valid_reg) begin
            out_data_reg <= dec_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OutWidth - $bits(iwd_result_t)){1'b0}}, out_data_reg};

    assign out_move       = in_valid_reg && out_ready;
    assign out_undec      = out_valid_reg && out_data_reg.op_class == OP_UNDEC;
    assign undec_clean    = out_data_reg.flag_bits == 8'd0 && out_data_reg.imm_value == 32'd0
                            && out_data_reg.register_list == 16'd0
                            && out_data_reg.dest_reg == 4'd0;
    assign out_branch     = out_valid_reg && out_data_reg.op_class == OP_B;
    assign branch_aligned = out_data_reg.imm_value[1:0] == 2'b00;

    // accepted words reach the decode stage, decoded words reach the output
    `IWD_ASSERT_NEXT(a_in_load, aclk, aresetn, in_take, in_valid_reg, "accepted word lost")
    `IWD_ASSERT_NEXT(a_out_load, aclk, aresetn, out_move, out_valid_reg, "decoded word lost")
    // undecoded words carry no flags, immediate, register list or destination
    `IWD_ASSERT_NOW(a_undec_clean, aclk, aresetn, out_undec, undec_clean, "undecoded fields set")
    // branch offsets are word aligned
    `IWD_ASSERT_NOW(a_branch_align, aclk, aresetn, out_branch, branch_aligned, "branch unaligned")

endmodule

/* verif/instruction_word_decoder_test.sv */
`timescale 1ns / 100ps

module instruction_word_decoder_test;
    import iwd_pkg::*;

    localparam int unsigned RES_BITS   = $bits(iwd_result_t);
    localparam int unsigned DRAIN_WAIT = 10;

    typedef enum logic [3:0] {
        G_MUL, G_MULL, G_SWAP, G_HALF, G_MRS, G_MSR_REG, G_MSR_IMM, G_BX, G_BLOCK,
        G_SINGLE, G_BRANCH, G_DP_SHIFT, G_RESERVED, G_DP_IMM, G_NONE
    } word_group_t;

    logic                 aclk;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [InstrWidth-1:0] s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [OutWidth-1:0]  m_tdata;

    logic [31:0]  word_queue [$];
    iwd_result_t  pending_decodes [$];
    int unsigned  words_total;
    int unsigned  words_accepted = 0;
    int unsigned  results_seen   = 0;
    int unsigned  mismatch_count = 0;
    int unsigned  send_gap       = 0;
    int unsigned  recv_stall     = 0;
    int unsigned  class_hits [0:31];
    int unsigned  group_hits [0:15];

    instruction_word_decoder dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
    end

    initial begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // first matching encoding group wins
    function automatic word_group_t classify_word(input logic [31:0] w);
        if ((w & MUL_MASK) == MUL_PAT)                                    return G_MUL;
        if ((w & MULL_MASK) == MULL_PAT)                                  return G_MULL;
        if ((w & SWP_MASK) == SWP_PAT)                                    return G_SWAP;
        if ((w & HW_MASK) == HW_PAT || (w & SGN_MASK) == SGN_PAT)         return G_HALF;
        if ((w & PSR_MASK) == MRS_PAT)                                    return G_MRS;
        if ((w & PSR_MASK) == MSR_PAT)                                    return G_MSR_REG;
        if ((w & IMM_MASK) == MSRI_PAT)                                   return G_MSR_IMM;
        if ((w & BX_MASK) == BX_PAT)                                      return G_BX;
        if ((w & GRP_MASK) == BLK_PAT)                                    return G_BLOCK;
        if ((w & GRP_MASK) == SDT_PAT || (w & SDTR_MASK) == SDTR_PAT)     return G_SINGLE;
        if ((w & GRP_MASK) == BR_PAT)                                     return G_BRANCH;
        if ((w & DPIS_MASK) == DPIS_PAT || (w & DPRS_MASK) == DPRS_PAT)   return G_DP_SHIFT;
        if ((w & IMM_MASK) == RSVD_PAT)                                   return G_RESERVED;
        if ((w & GRP_MASK) == DPI_PAT)                                    return G_DP_IMM;
        return G_NONE;
    endfunction

    function automatic logic [31:0] rotate_imm8(input logic [31:0] w);
        logic [31:0] v;
        int unsigned amt;
        v   = {24'd0, w[7:0]};
        amt = 2 * w[11:8];
        // a shift by 32 yields zero, so amt == 0 leaves v alone
        return (v >> amt) | (v << (32 - amt));
    endfunction

    // L, U, P, W shared by the transfer groups
    function automatic logic [7:0] transfer_bits(input logic [31:0] w);
        logic [7:0] f;
        f = '0;
        f[FLAG_L] = w[20];
        f[FLAG_U] = w[23];
        f[FLAG_P] = w[24];
        f[FLAG_W] = w[21];
        return f;
    endfunction

    function automatic iwd_result_t decode_word(input logic [31:0] w);
        iwd_result_t d;
        d = '0;
        d.op_class  = OP_UNDEC;
        d.cond_code = w[31:28];
        case (classify_word(w))
            G_MUL, G_MULL: begin
                if (classify_word(w) == G_MUL)
                    d.op_class = w[21] ? OP_MLA : OP_MUL;
                else
                    d.op_class = OP_UMULL + 5'(w[22:21]);
                d.flag_bits[FLAG_S] = w[20];
                d.dest_reg   = w[19:16];
                d.base_reg   = w[15:12];
                d.shift_reg  = w[11:8];
                d.second_reg = w[3:0];
            end
            G_SWAP: begin
                if (w[3:0] != 4'hF) begin
                    d.op_class = OP_SWP;
                    d.flag_bits[FLAG_B] = w[22];
                    d.base_reg   = w[19:16];
                    d.dest_reg   = w[15:12];
                    d.second_reg = w[3:0];
                end
            end
            G_HALF: begin
                if ((w & HW_MASK) == HW_PAT)
                    d.op_class = w[20] ? OP_LDRH : OP_STRH;
                else
                    d.op_class = w[5] ? OP_LDRSH : OP_LDRSB;
                d.flag_bits = transfer_bits(w);
                d.flag_bits[FLAG_I] = w[22];
                d.base_reg   = w[19:16];
                d.dest_reg   = w[15:12];
                d.second_reg = w[3:0];
                d.imm_value  = {24'd0, w[11:8], w[3:0]};
            end
            G_MRS: begin
                d.op_class = OP_MRS;
                d.flag_bits[FLAG_P] = w[22];
                d.dest_reg = w[15:12];
            end
            G_MSR_REG: begin
                d.op_class = OP_MSR;
                d.flag_bits[FLAG_P] = w[22];
                d.second_reg = w[3:0];
            end
            G_MSR_IMM: begin
                d.op_class = OP_MSR;
                d.flag_bits[FLAG_P] = w[22];
                d.flag_bits[FLAG_I] = 1'b1;
                d.imm_value = rotate_imm8(w);
            end
            G_BX: begin
                d.op_class = OP_BX;
                d.base_reg = w[3:0];
            end
            G_BLOCK: begin
                d.op_class = w[20] ? OP_LDM : OP_STM;
                d.flag_bits = transfer_bits(w);
                d.flag_bits[FLAG_S] = w[22];
                d.base_reg      = w[19:16];
                d.register_list = w[15:0];
            end
            G_SINGLE: begin
                d.op_class = w[20] ? OP_LDR : OP_STR;
                d.flag_bits = transfer_bits(w);
                d.flag_bits[FLAG_B] = w[22];
                d.base_reg = w[19:16];
                d.dest_reg = w[15:12];
                if (w[25]) begin
                    d.flag_bits[FLAG_I] = 1'b1;
                    d.second_reg  = w[3:0];
                    d.shift_kind  = w[6:5];
                    d.shift_count = w[11:7];
                end else begin
                    d.imm_value = {20'd0, w[11:0]};
                end
            end
            G_BRANCH: begin
                d.op_class = OP_B;
                d.flag_bits[FLAG_L] = w[24];
                d.imm_value = 32'($signed(w[23:0])) << 2;
            end
            G_DP_SHIFT: begin
                d.op_class = OP_ALU;
                d.alu_op   = w[24:21];
                d.flag_bits[FLAG_S] = w[20];
                d.dest_reg   = w[15:12];
                d.base_reg   = w[19:16];
                d.second_reg = w[3:0];
                d.shift_kind = w[6:5];
                d.imm_value  = {20'd0, w[11:0]};
                if (w[4]) begin
                    d.flag_bits[FLAG_SR] = 1'b1;
                    d.shift_reg = w[11:8];
                end else begin
                    d.shift_count = w[11:7];
                end
            end
            G_DP_IMM: begin
                d.op_class = OP_ALU;
                d.alu_op   = w[24:21];
                d.flag_bits[FLAG_S] = w[20];
                d.flag_bits[FLAG_I] = 1'b1;
                d.dest_reg  = w[15:12];
                d.base_reg  = w[19:16];
                d.imm_value = rotate_imm8(w);
            end
            default: ;
        endcase
        return d;
    endfunction

    // zero-wait bursts for a stretch, random waits otherwise
    function automatic int unsigned draw_wait(input int unsigned idx, input int unsigned period);
        return ((idx / period) % 3 == 1) ? 0 : $urandom_range(7);
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatch_count++;
        end
    endtask

    // input side
    always @(posedge aclk) begin
        logic [31:0] w;
        iwd_result_t predicted;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                w = s_tdata;
                predicted = decode_word(w);
                pending_decodes.insert(pending_decodes.size(), predicted);
                class_hits[predicted.op_class]++;
                group_hits[classify_word(w)]++;
                words_accepted++;
                send_gap = draw_wait(words_accepted, 150);
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (word_queue.size() > 0) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= word_queue.pop_front();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result side
    always @(posedge aclk) begin
        iwd_result_t got;
        iwd_result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata[RES_BITS-1:0];
                results_seen++;
                check_field("pad", '0, 32'(m_tdata[OutWidth-1:RES_BITS]));
                if (pending_decodes.size() == 0) begin
                    $error("result transfer with nothing outstanding: %0h", m_tdata);
                    mismatch_count++;
                end else begin
                    want = pending_decodes.pop_front();
                    check_field("op_class",  32'(want.op_class),  32'(got.op_class));
                    check_field("cond_code", 32'(want.cond_code), 32'(got.cond_code));
                    check_field("alu_op",    32'(want.alu_op),    32'(got.alu_op));
                    check_field("dest_reg",  32'(want.dest_reg),  32'(got.dest_reg));
                    check_field("base_reg",  32'(want.base_reg),  32'(got.base_reg));
                    check_field("shift_reg", 32'(want.shift_reg), 32'(got.shift_reg));
                    check_field("second_reg", 32'(want.second_reg), 32'(got.second_reg));
                    check_field("flag_bits", 32'(want.flag_bits), 32'(got.flag_bits));
                    check_field("imm_value", want.imm_value,      got.imm_value);
                    check_field("shift_kind", 32'(want.shift_kind), 32'(got.shift_kind));
                    check_field("shift_count", 32'(want.shift_count), 32'(got.shift_count));
                    check_field("register_list", 32'(want.register_list),
                                32'(got.register_list));
                end
                recv_stall = draw_wait(results_seen, 110);
            end
            if (recv_stall > 0) begin
                recv_stall--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        logic [31:0] directed_words [$];
        logic [31:0] shape_mask [20];
        logic [31:0] shape_pat [20];
        logic [31:0] w;
        int unsigned pick;
        int unsigned classes_hit;
        int unsigned groups_hit;

        directed_words = '{
            32'h0000_0000,  // all zero: AND, immediate shift
            32'hFFFF_FFFF,  // condition 15, interrupt space
            32'h0031_2394,  // MLA with S
            32'hE080_0091,  // UMULL
            32'h00F5_4397,  // SMLAL with S
            32'hE140_1092,  // SWPB
            32'hE101_F09F,  // swap from r15 stays undecoded
            32'hE1D0_1FB4,  // LDRH immediate
            32'hE00A_20B3,  // STRH register
            32'hE1F0_10D0,  // LDRSB
            32'h01BF_EFFF,  // LDRSH, odd fields
            32'hE14F_0000,  // MRS from SPSR
            32'hE129_F00E,  // MSR register
            32'hE368_F4FF,  // MSR rotated immediate
            32'hE12F_FF1E,  // BX
            32'hE12F_FF3E,  // near-BX in misc space: ALU register shift
            32'hE8FD_FFFF,  // LDM with S bit, full list
            32'hE92D_0000,  // STM, empty list
            32'hE59F_0FFF,  // LDR, largest offset
            32'hE7C1_2FE3,  // STRB register offset
            32'hE7F0_00F0,  // bit 4 set in register-offset space: undecoded
            32'hEAFF_FFFE,  // B back by 8
            32'h0B7F_FFFF,  // BL, largest forward
            32'hE300_0000,  // reserved immediate space
            32'hF3A0_0CFF,  // MOV rotated immediate, condition 15
            32'hE061_2352,  // RSB by register
            32'hEE00_0010,  // coprocessor space
            32'hE000_00F0   // bit 7 and bit 4 set, no transfer match: undecoded
        };
        shape_mask = '{
            MUL_MASK, MULL_MASK, SWP_MASK, HW_MASK, SGN_MASK, PSR_MASK, PSR_MASK,
            IMM_MASK, BX_MASK, GRP_MASK, GRP_MASK, SDTR_MASK, GRP_MASK, DPIS_MASK,
            DPRS_MASK, IMM_MASK, GRP_MASK, GRP_MASK, GRP_MASK, 32'h0F90_0000
        };
        shape_pat = '{
            MUL_PAT, MULL_PAT, SWP_PAT, HW_PAT, SGN_PAT, MRS_PAT, MSR_PAT,
            MSRI_PAT, BX_PAT, BLK_PAT, SDT_PAT, SDTR_PAT, BR_PAT, DPIS_PAT,
            DPRS_PAT, RSVD_PAT, DPI_PAT, 32'h0E00_0000, 32'h0C00_0000, 32'h0100_0000
        };

        foreach (class_hits[i]) class_hits[i] = 0;
        foreach (group_hits[i]) group_hits[i] = 0;

        foreach (directed_words[i]) word_queue.insert(word_queue.size(), directed_words[i]);
        // mostly well-formed encodings with random content, the rest raw noise
        repeat (1800) begin
            w = $urandom;
            if ($urandom_range(99) >= 15) begin
                pick = $urandom_range(19);
                w = (w & ~shape_mask[pick]) | shape_pat[pick];
            end
            word_queue.insert(word_queue.size(), w);
        end
        words_total = word_queue.size();

        while (words_accepted < words_total) @(posedge aclk);
        while (pending_decodes.size() > 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        classes_hit = 0;
        groups_hit  = 0;
        foreach (class_hits[i]) if (class_hits[i] > 0) classes_hit++;
        foreach (group_hits[i]) if (group_hits[i] > 0) groups_hit++;
        $display("Decoded %0d words into %0d results under random input gaps and output stalls.",
                 words_accepted, results_seen);
        $display("Hit %0d of 21 result classes and %0d of 15 encoding groups; %0d mismatches.",
                 classes_hit, groups_hit, mismatch_count);
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

/* sim.f */
+incdir+design
design/iwd_pkg.sv
design/instruction_word_decoder.sv
verif/instruction_word_decoder_test.sv
